@@ hw/rtl/tccw_pkg.sv @@
package tccw_pkg;

	// default geometry
	localparam int COLUMNS_DEF    = 80;
	localparam int ROWS_DEF       = 25;
	localparam int TAB_SPACES_DEF = 4;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// port field widths
	localparam int OP_W    = 3;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;
	localparam int POS_W   = 8;
	localparam int ADDR_IN_W = 11;
	localparam int LOC_W   = 11;
	localparam int DATA_W  = 16;
	localparam int ATTR_W  = 8;

	// widest cursor fields over the whole parameter range
	localparam int COL_MAX_W = 7;
	localparam int ROW_MAX_W = 5;

	localparam logic [ATTR_W-1:0] FILL_ATTR_RESET = 8'd15;

	localparam logic [CHAR_W-1:0] CH_NULL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	// operation codes on the input channel
	localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
	localparam logic [OP_W-1:0] OP_SETCUR = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_SCROLL = 3'd3;
	localparam logic [OP_W-1:0] OP_READ   = 3'd4;

	// classified command kinds
	typedef enum logic [3:0] {
		K_PUT,
		K_TAB,
		K_NEWLINE,
		K_RETURN,
		K_SETCUR,
		K_CLEAR,
		K_SCROLL,
		K_READ,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [CHAR_W-1:0]    char_code;
		logic [ATTR_W-1:0]    attr;
		logic [COL_MAX_W-1:0] col;
		logic [ROW_MAX_W-1:0] row;
		logic [ADDR_IN_W-1:0] addr;
	} cmd_t;

endpackage

@@ hw/rtl/tccw_if.sv @@
interface tccw_in_if import tccw_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [CHAR_W-1:0]    char_code;
	logic [COLOR_W-1:0]   back_color;
	logic [COLOR_W-1:0]   fore_color;
	logic [POS_W-1:0]     cursor_col;
	logic [POS_W-1:0]     cursor_row;
	logic [ADDR_IN_W-1:0] cell_address;

	modport source (
		output valid, operation, char_code, back_color, fore_color,
		       cursor_col, cursor_row, cell_address,
		input  ready
	);
	modport sink (
		input  valid, operation, char_code, back_color, fore_color,
		       cursor_col, cursor_row, cell_address,
		output ready
	);
endinterface

interface tccw_out_if import tccw_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [LOC_W-1:0]  cursor_pos;
	logic [DATA_W-1:0] read_data;

	modport source (output valid, cursor_pos, read_data, input ready);
	modport sink (input valid, cursor_pos, read_data, output ready);
endinterface

@@ hw/rtl/tccw_ram.sv @@
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/tccw_fifo.sv @@
module tccw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data,
	input  logic             pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/tccw_front.sv @@
module tccw_front import tccw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	tccw_in_if.sink cmd,
	input  logic    q_ready,
	input  logic    init_busy,
	output logic    q_push,
	output cmd_t    q_entry
);

	localparam int CELLS = COLUMNS * ROWS;

	assign cmd.ready = q_ready && !init_busy;
	assign q_push    = cmd.valid && cmd.ready;

	always_comb begin
		q_entry           = '0;
		q_entry.kind      = K_NOP;
		q_entry.char_code = (cmd.char_code == CH_NULL) ? CH_SPACE : cmd.char_code;
		q_entry.attr      = {cmd.back_color, cmd.fore_color};
		q_entry.col       = (32'(cmd.cursor_col) >= COLUMNS) ?
		                    COL_MAX_W'(COLUMNS - 1) : COL_MAX_W'(cmd.cursor_col);
		q_entry.row       = (32'(cmd.cursor_row) >= ROWS) ?
		                    ROW_MAX_W'(ROWS - 1) : ROW_MAX_W'(cmd.cursor_row);
		q_entry.addr      = cmd.cell_address;
		case (cmd.operation)
			OP_PUT: begin
				case (cmd.char_code)
					CH_TAB: begin
						q_entry.kind      = K_TAB;
						q_entry.char_code = CH_SPACE;
					end
					CH_NEWLINE: q_entry.kind = K_NEWLINE;
					CH_RETURN:  q_entry.kind = K_RETURN;
					default:    q_entry.kind = K_PUT;
				endcase
			end
			OP_SETCUR: q_entry.kind = K_SETCUR;
			OP_CLEAR:  q_entry.kind = K_CLEAR;
			OP_SCROLL: q_entry.kind = K_SCROLL;
			// out-of-range reads return zero and touch nothing
			OP_READ:   q_entry.kind = (32'(cmd.cell_address) < CELLS) ? K_READ : K_NOP;
			default:   q_entry.kind = K_NOP;
		endcase
	end

endmodule

@@ hw/rtl/tccw_back.sv @@
module tccw_back import tccw_pkg::*; #(
	parameter int COLUMNS    = COLUMNS_DEF,
	parameter int ROWS       = ROWS_DEF,
	parameter int TAB_SPACES = TAB_SPACES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	input  logic              q_valid,
	input  cmd_t              q_entry,
	output logic              q_pop,
	output logic              init_busy,
	tccw_out_if.source        rsp
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W  = $clog2(TAB_SPACES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_COPY,
		ST_TAIL,
		ST_BLANK,
		ST_READ,
		ST_READ_WAIT,
		ST_RESP
	} state_t;

	state_t              state_q;
	logic                init_q;
	kind_t               kind_q;
	logic [CHAR_W-1:0]   char_q;
	logic [ATTR_W-1:0]   attr_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [CNT_W-1:0]    count_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    line_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic [ATTR_W-1:0]   fill_attr_q;
	logic [DATA_W-1:0]   rd_q;
	logic                rsp_valid_q;
	logic [LOC_W-1:0]    loc_q;
	logic [DATA_W-1:0]   data_q;
	logic                wv_s1;
	logic [ADDR_W-1:0]   wa_s1;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [DATA_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [DATA_W-1:0]   mem_rdata;
	logic [31:0]         cur_lin;
	logic [DATA_W-1:0]   blank_word;
	logic                last_col;
	logic                last_row;

	assign cur_lin    = 32'(line_q) * COLUMNS + 32'(col_q);
	assign blank_word = {(init_q ? FILL_ATTR_RESET : fill_attr_q), CH_SPACE};
	assign last_col   = (col_q == COL_W'(COLUMNS - 1));
	assign last_row   = (line_q == ROW_W'(ROWS - 1));

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign init_busy = init_q;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_pos = loc_q;
	assign rsp.read_data  = data_q;

	// write port: pending copy word first, then blank fill, then character
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = blank_word;
		if (wv_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wa_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == ST_BLANK) begin
			mem_we    = 1'b1;
		end else if (state_q == ST_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = cur_lin[ADDR_W-1:0];
			mem_wdata = {attr_q, char_q};
		end
		mem_raddr = (state_q == ST_READ) ? addr_q : ptr_q + ADDR_W'(COLUMNS);
	end

	tccw_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BLANK;
			init_q      <= 1'b1;
			kind_q      <= K_NOP;
			char_q      <= '0;
			attr_q      <= '0;
			addr_q      <= '0;
			count_q     <= '0;
			col_q       <= '0;
			line_q      <= '0;
			ptr_q       <= '0;
			fill_attr_q <= FILL_ATTR_RESET;
			rd_q        <= '0;
			rsp_valid_q <= 1'b0;
			loc_q       <= '0;
			data_q      <= '0;
			wv_s1       <= 1'b0;
			wa_s1       <= '0;
		end else begin
			wv_s1 <= (state_q == ST_COPY);
			if (cfg_we) begin
				fill_attr_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						kind_q  <= q_entry.kind;
						char_q  <= q_entry.char_code;
						attr_q  <= q_entry.attr;
						addr_q  <= ADDR_W'(q_entry.addr);
						rd_q    <= '0;
						ptr_q   <= '0;
						count_q <= (q_entry.kind == K_TAB) ? CNT_W'(TAB_SPACES) : CNT_W'(1);
						case (q_entry.kind)
							K_PUT: state_q <= ST_PUT;
							K_TAB: state_q <= ST_PUT;
							K_NEWLINE: begin
								col_q <= '0;
								if (last_row) begin
									state_q <= ST_COPY;
								end else begin
									line_q  <= line_q + 1'b1;
									state_q <= ST_RESP;
								end
							end
							K_RETURN: begin
								col_q   <= '0;
								state_q <= ST_RESP;
							end
							K_SETCUR: begin
								col_q   <= COL_W'(q_entry.col);
								line_q  <= ROW_W'(q_entry.row);
								state_q <= ST_RESP;
							end
							K_CLEAR:  state_q <= ST_BLANK;
							K_SCROLL: state_q <= ST_COPY;
							K_READ:   state_q <= ST_READ;
							default:  state_q <= ST_RESP;
						endcase
					end
				end
				ST_PUT: begin
					count_q <= count_q - 1'b1;
					if (last_col) begin
						col_q <= '0;
						if (last_row) begin
							// wrap off the bottom: scroll, cursor stays on last row
							ptr_q   <= '0;
							state_q <= ST_COPY;
						end else begin
							line_q  <= line_q + 1'b1;
							state_q <= (count_q == CNT_W'(1)) ? ST_RESP : ST_PUT;
						end
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= (count_q == CNT_W'(1)) ? ST_RESP : ST_PUT;
					end
				end
				ST_COPY: begin
					wa_s1 <= ptr_q;
					if (ptr_q == ADDR_W'(CELLS - COLUMNS - 1)) begin
						state_q <= ST_TAIL;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_TAIL: begin
					ptr_q   <= ADDR_W'((ROWS - 1) * COLUMNS);
					state_q <= ST_BLANK;
				end
				ST_BLANK: begin
					if (ptr_q == ADDR_W'(CELLS - 1)) begin
						if (init_q) begin
							init_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							case (kind_q)
								K_CLEAR: begin
									col_q   <= '0;
									line_q  <= '0;
									state_q <= ST_RESP;
								end
								K_SCROLL: begin
									if (line_q != '0) begin
										line_q <= line_q - 1'b1;
									end
									state_q <= ST_RESP;
								end
								K_PUT, K_TAB: begin
									state_q <= (count_q == '0) ? ST_RESP : ST_PUT;
								end
								default: state_q <= ST_RESP;
							endcase
						end
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_READ: state_q <= ST_READ_WAIT;
				ST_READ_WAIT: begin
					rd_q    <= mem_rdata;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						loc_q       <= cur_lin[LOC_W-1:0];
						data_q      <= rd_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(line_q) < ROWS))
		else $error("cursor outside the screen");

	a_copy_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		wv_s1 |-> $past(state_q == ST_COPY))
		else $error("copy write without a preceding copy read");

	a_word_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result word loaded outside the response state");

	a_no_pop_while_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !q_pop)
		else $error("command taken during the clearing pass");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ_WAIT) |-> !mem_we)
		else $error("store written while a cell read is in flight");

endmodule

@@ hw/rtl/text_console_cell_writer_unit.sv @@
// Channel   Dir  Word fields
// cmd       in   operation, char_code, back_color, fore_color, cursor_col, cursor_row,
//                cell_address
// rsp       out  cursor_pos, read_data
// cfg       in   cfg_we / cfg_wdata -> fill_attribute
//
// At the back end a tab puts TAB_SPACES spaces, and a wrap or newline off the last row
// scrolls the store. The single write port of the cell RAM makes clear and scroll
// write one cell at a time. After reset a clearing pass fills the store; cmd is
// held not ready meanwhile. A two-word queue parts front and back, and the result
// register lets the next word start while rsp is stalled.
module text_console_cell_writer_unit import tccw_pkg::*; #(
	parameter int COLUMNS    = COLUMNS_DEF,
	parameter int ROWS       = ROWS_DEF,
	parameter int TAB_SPACES = TAB_SPACES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	tccw_in_if.sink           cmd,
	tccw_out_if.source        rsp
);

	localparam int CMD_W = $bits(cmd_t);

	logic             q_ready;
	logic             q_push;
	cmd_t             q_in;
	logic             q_valid;
	logic [CMD_W-1:0] q_out_bits;
	logic             q_pop;
	logic             init_busy;

	tccw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.cmd       (cmd),
		.q_ready   (q_ready),
		.init_busy (init_busy),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	tccw_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.push_ready (q_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_out_bits),
		.pop        (q_pop)
	);

	tccw_back #(
		.COLUMNS    (COLUMNS),
		.ROWS       (ROWS),
		.TAB_SPACES (TAB_SPACES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_entry   (cmd_t'(q_out_bits)),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.rsp       (rsp)
	);

endmodule

@@ tb/tccw_screen_checker.sv @@
`timescale 1ns / 1ps

module tccw_screen_checker import tccw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ATTR_W-1:0] cfg_wdata,
	tccw_in_if                cmd,
	tccw_out_if               rsp,
	output int                mismatches,
	output int                pending
);

	localparam int COLS  = COLUMNS_DEF;
	localparam int ROWS  = ROWS_DEF;
	localparam int CELLS = COLS * ROWS;

	typedef struct packed {
		logic [LOC_W-1:0]  location;
		logic [DATA_W-1:0] rd_word;
	} reply_t;

	logic [DATA_W-1:0]    screen [CELLS];
	logic [COL_MAX_W-1:0] cur_col;
	logic [ROW_MAX_W-1:0] cur_row;
	logic [ATTR_W-1:0]    fill;
	reply_t               expected_replies [$];

	function automatic logic [DATA_W-1:0] fill_word();
		return {fill, CH_SPACE};
	endfunction

	function automatic void scroll_up();
		int i;
		for (i = 0; i < CELLS - COLS; i++)
			screen[i] = screen[i + COLS];
		for (i = CELLS - COLS; i < CELLS; i++)
			screen[i] = fill_word();
		if (cur_row != '0)
			cur_row--;
	endfunction

	function automatic void line_feed();
		cur_col = '0;
		if (cur_row == ROWS - 1) begin
			scroll_up();
			cur_row = ROW_MAX_W'(ROWS - 1);
		end else begin
			cur_row++;
		end
	endfunction

	function automatic void put_glyph(input logic [CHAR_W-1:0] ch,
	                                  input logic [COLOR_W-1:0] back,
	                                  input logic [COLOR_W-1:0] fore);
		int idx;
		idx = cur_row * COLS + cur_col;
		screen[idx] = {back, fore, (ch == CH_NULL) ? CH_SPACE : ch};
		if (cur_col == COLS - 1)
			line_feed();
		else
			cur_col++;
	endfunction

	function automatic reply_t apply_command(input logic [OP_W-1:0] op,
	                                         input logic [CHAR_W-1:0] ch,
	                                         input logic [COLOR_W-1:0] back,
	                                         input logic [COLOR_W-1:0] fore,
	                                         input logic [POS_W-1:0] col,
	                                         input logic [POS_W-1:0] row,
	                                         input logic [ADDR_IN_W-1:0] addr);
		reply_t r;
		int i;
		r.rd_word = '0;
		case (op)
			OP_PUT: begin
				if (ch == CH_TAB) begin
					for (i = 0; i < TAB_SPACES_DEF; i++)
						put_glyph(CH_SPACE, back, fore);
				end else if (ch == CH_NEWLINE) begin
					line_feed();
				end else if (ch == CH_RETURN) begin
					cur_col = '0;
				end else begin
					put_glyph(ch, back, fore);
				end
			end
			OP_SETCUR: begin
				cur_col = (col >= COLS) ? COL_MAX_W'(COLS - 1) : COL_MAX_W'(col);
				cur_row = (row >= ROWS) ? ROW_MAX_W'(ROWS - 1) : ROW_MAX_W'(row);
			end
			OP_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen[i] = fill_word();
				cur_col = '0;
				cur_row = '0;
			end
			OP_SCROLL: scroll_up();
			OP_READ: begin
				if (addr < CELLS)
					r.rd_word = screen[addr];
			end
			default: ;
		endcase
		r.location = LOC_W'(cur_row * COLS + cur_col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int i;
		if (!arst_n) begin
			fill = FILL_ATTR_RESET;
			for (i = 0; i < CELLS; i++)
				screen[i] = fill_word();
			cur_col = '0;
			cur_row = '0;
			expected_replies.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				fill = cfg_wdata;
			if (cmd.valid && cmd.ready)
				expected_replies.push_back(apply_command(cmd.operation, cmd.char_code,
					cmd.back_color, cmd.fore_color, cmd.cursor_col, cmd.cursor_row,
					cmd.cell_address));
			if (rsp.valid && rsp.ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: reply word with none expected: location %0d data %h",
						$time, rsp.cursor_pos, rsp.read_data);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (rsp.cursor_pos !== want.location) begin
						$display("%0t: cursor location expected %0d, got %0d",
							$time, want.location, rsp.cursor_pos);
						mismatches++;
					end
					if (rsp.read_data !== want.rd_word) begin
						$display("%0t: read data expected %h, got %h",
							$time, want.rd_word, rsp.read_data);
						mismatches++;
					end
				end
			end
			pending <= expected_replies.size();
		end
	end

endmodule

@@ tb/text_console_cell_writer_unit_tb.sv @@
`timescale 1ns / 1ps

module text_console_cell_writer_unit_tb import tccw_pkg::*; ;

	localparam int CELLS       = COLUMNS_DEF * ROWS_DEF;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 2 * CELLS + 16;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [CHAR_W-1:0]    ch;
		logic [COLOR_W-1:0]   back;
		logic [COLOR_W-1:0]   fore;
		logic [POS_W-1:0]     col;
		logic [POS_W-1:0]     row;
		logic [ADDR_IN_W-1:0] addr;
	} console_cmd_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ATTR_W-1:0] cfg_wdata;
	logic              long_hold = 1'b0;
	int                sender_idle = 0;
	int                receiver_stall = 0;
	int                held_cycles;
	int                cursor_hint = 0;
	int                mismatches;
	int                pending;

	tccw_in_if  cmd_if ();
	tccw_out_if rsp_if ();

	text_console_cell_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.rsp       (rsp_if)
	);

	tccw_screen_checker screen_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd_if),
		.rsp        (rsp_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// reply side: random stalls, or one long hold-off while long_hold is up
	initial begin
		rsp_if.ready = 1'b0;
		held_cycles = 0;
		forever begin
			@(posedge clk);
			if (long_hold && held_cycles < LONG_HOLD) begin
				rsp_if.ready <= 1'b0;
				held_cycles++;
			end else begin
				if (!long_hold)
					held_cycles = 0;
				rsp_if.ready <= ($urandom_range(99) >= receiver_stall);
			end
		end
	end

	initial begin
		#150_000_000;
		$display("text_console_cell_writer_unit test failed");
		$finish;
	end

	function automatic console_cmd_t make_cmd(input logic [OP_W-1:0] op,
	                                          input logic [CHAR_W-1:0] ch,
	                                          input logic [COLOR_W-1:0] back,
	                                          input logic [COLOR_W-1:0] fore,
	                                          input logic [POS_W-1:0] col,
	                                          input logic [POS_W-1:0] row,
	                                          input logic [ADDR_IN_W-1:0] addr);
		console_cmd_t c;
		c = '{op, ch, back, fore, col, row, addr};
		return c;
	endfunction

	function automatic console_cmd_t random_command();
		console_cmd_t c;
		int pick;
		int a;
		c.op   = OP_PUT;
		c.ch   = CHAR_W'($urandom_range(255));
		c.back = COLOR_W'($urandom_range(15));
		c.fore = COLOR_W'($urandom_range(15));
		c.col  = POS_W'($urandom_range(255));
		c.row  = POS_W'($urandom_range(255));
		c.addr = ADDR_IN_W'($urandom_range((1 << ADDR_IN_W) - 1));
		pick = $urandom_range(999);
		if (pick < 600) begin
			if ($urandom_range(99) < 15) begin
				case ($urandom_range(3))
					0: c.ch = CH_TAB;
					1: c.ch = CH_NEWLINE;
					2: c.ch = CH_RETURN;
					default: c.ch = CH_NULL;
				endcase
			end
		end else if (pick < 710) begin
			c.op = OP_SETCUR;
			// half the moves land near the bottom right to force wraps and scrolls
			if ($urandom_range(1)) begin
				c.col = POS_W'($urandom_range(COLUMNS_DEF - 10, COLUMNS_DEF - 1));
				c.row = POS_W'($urandom_range(ROWS_DEF - 5, ROWS_DEF - 1));
			end
			cursor_hint = ((c.row >= ROWS_DEF) ? ROWS_DEF - 1 : int'(c.row)) * COLUMNS_DEF
				+ ((c.col >= COLUMNS_DEF) ? COLUMNS_DEF - 1 : int'(c.col));
		end else if (pick < 950) begin
			c.op = OP_READ;
			if ($urandom_range(1)) begin
				a = cursor_hint - COLUMNS_DEF + $urandom_range(2 * COLUMNS_DEF);
				c.addr = ADDR_IN_W'((a < 0) ? 0 : a);
			end
		end else if (pick < 965) begin
			c.op = OP_CLEAR;
		end else if (pick < 990) begin
			c.op = OP_SCROLL;
		end else begin
			c.op = OP_W'($urandom_range(int'(OP_READ) + 1, (1 << OP_W) - 1));
		end
		return c;
	endfunction

	task automatic send_word(input console_cmd_t c);
		while ($urandom_range(99) < sender_idle) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid        <= 1'b1;
		cmd_if.operation    <= c.op;
		cmd_if.char_code    <= c.ch;
		cmd_if.back_color   <= c.back;
		cmd_if.fore_color   <= c.fore;
		cmd_if.cursor_col   <= c.col;
		cmd_if.cursor_row   <= c.row;
		cmd_if.cell_address <= c.addr;
		do
			@(posedge clk);
		while (!cmd_if.ready);
	endtask

	task automatic drain();
		cmd_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic set_fill(input logic [ATTR_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int count, input int idle, input int stall);
		sender_idle = idle;
		receiver_stall <= stall;
		repeat (count)
			send_word(random_command());
	endtask

	initial begin
		int op;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = FILL_ATTR_RESET;
		cmd_if.valid        = 1'b0;
		cmd_if.operation    = OP_PUT;
		cmd_if.char_code    = '0;
		cmd_if.back_color   = '0;
		cmd_if.fore_color   = '0;
		cmd_if.cursor_col   = '0;
		cmd_if.cursor_row   = '0;
		cmd_if.cell_address = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: store after reset, control characters, wraps, scrolls, clamping
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, ADDR_IN_W'(CELLS - 1)));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, ADDR_IN_W'(CELLS)));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, '1));
		send_word(make_cmd(OP_PUT, 8'h41, 4'hF, 4'h0, '0, '0, '0));
		send_word(make_cmd(OP_PUT, CH_NULL, 4'h0, 4'hF, '0, '0, '0));
		send_word(make_cmd(OP_PUT, 8'hFF, 4'hA, 4'h5, '0, '0, '0));
		send_word(make_cmd(OP_PUT, CH_TAB, 4'h3, 4'hC, '0, '0, '0));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, 11'd1));
		send_word(make_cmd(OP_PUT, CH_RETURN, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_PUT, CH_NEWLINE, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_SETCUR, '0, '0, '0, '1, '1, '0));
		send_word(make_cmd(OP_PUT, 8'h7E, 4'h1, 4'hE, '0, '0, '0));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, ADDR_IN_W'(CELLS - COLUMNS_DEF - 1)));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, ADDR_IN_W'(CELLS - 1)));
		send_word(make_cmd(OP_SETCUR, '0, '0, '0, POS_W'(COLUMNS_DEF - 1), '0, '0));
		send_word(make_cmd(OP_PUT, 8'h80, 4'h7, 4'h2, '0, '0, '0));
		send_word(make_cmd(OP_SETCUR, '0, '0, '0, POS_W'(COLUMNS_DEF - 2),
			POS_W'(ROWS_DEF - 1), '0));
		send_word(make_cmd(OP_PUT, CH_TAB, 4'h9, 4'h6, '0, '0, '0));
		send_word(make_cmd(OP_PUT, CH_NEWLINE, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_SCROLL, '0, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_SETCUR, '0, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_SCROLL, '0, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, ADDR_IN_W'(CELLS - 2 * COLUMNS_DEF)));
		send_word(make_cmd(OP_CLEAR, '0, '0, '0, '0, '0, '0));
		send_word(make_cmd(OP_READ, '0, '0, '0, '0, '0, 11'd1));
		for (op = int'(OP_READ) + 1; op < (1 << OP_W); op++)
			send_word(make_cmd(OP_W'(op), '0, '0, '0, '0, '0, '0));

		set_fill('0);
		run_phase(200, 0, 0);
		set_fill('1);
		run_phase(200, 80, 0);
		set_fill(ATTR_W'($urandom_range(255)));
		run_phase(200, 0, 80);
		set_fill(ATTR_W'($urandom_range(255)));
		run_phase(200, 16, 16);

		// receiver holds off while words keep coming, so the input backs up
		set_fill(FILL_ATTR_RESET);
		long_hold <= 1'b1;
		run_phase(50, 0, 0);
		long_hold <= 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("text_console_cell_writer_unit test passed");
		else
			$display("text_console_cell_writer_unit test failed");
		$finish;
	end

endmodule
